### hw/rtl/sv39_page_table_builder_unit_defines.svh
// Assertion macros shared by the Sv39 page table builder RTL.
// Depends on nothing; files that check their own logic include it.
`ifndef SV39_PAGE_TABLE_BUILDER_UNIT_DEFINES_SVH
`define SV39_PAGE_TABLE_BUILDER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define SV39PTB_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);
`define SV39PTB_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);
`else
`define SV39PTB_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg)
`define SV39PTB_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg)
`endif

`endif

### hw/rtl/sv39ptb_pkg.sv
// Types, constants and codes of the Sv39 page table builder.
// Depends on nothing; the pointer unit, walker and top level import it.
package sv39ptb_pkg;

	localparam int TABLE_PAGES_DEF   = 64;
	localparam int ENTRIES_PER_TABLE = 512;
	localparam int IDX_W             = 9;
	localparam int VPN_W             = 27;
	localparam int PPN_W             = 44;
	localparam int PTE_W             = 54;
	localparam int PERM_W            = 8;
	localparam int PPN_SHIFT         = 10;

	typedef struct packed {
		logic [VPN_W-1:0]  virt_page;
		logic [PPN_W-1:0]  phys_page;
		logic [PERM_W-1:0] permissions;
		logic              last_page;
	} in_item_t;

	typedef struct packed {
		logic [PTE_W-1:0] leaf_entry;
		logic [1:0]       tables_added;
		logic             out_of_tables;
		logic             region_end;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHK2,
		ST_CHK1,
		ST_ALLOC,
		ST_WR2,
		ST_WR1,
		ST_WR0,
		ST_DONE
	} walk_state_t;

	typedef enum logic {
		PTR_SUB,
		PTR_ADD
	} ptr_op_t;

	typedef struct packed {
		ptr_op_t          op;
		logic [PPN_W-1:0] operand;
	} ptr_req_t;

	typedef struct packed {
		logic [PPN_W-1:0] result;
		logic             below_free;
	} ptr_rsp_t;

endpackage

### hw/rtl/sv39ptb_ram.sv
// Generic single-port RAM with a registered read.
// Depends on nothing.
module sv39ptb_ram #(
	parameter int WIDTH = 54,
	parameter int DEPTH = 32768
) (
	input  logic                     clk,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic                     we,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

### hw/rtl/sv39ptb_ptr_unit.sv
// Shared 44-bit add and subtract unit for table pointers, with the taken-page check.
// Depends on sv39ptb_pkg.
module sv39ptb_ptr_unit import sv39ptb_pkg::*; #(
	parameter int TABLE_PAGES = TABLE_PAGES_DEF
) (
	input  logic [PPN_W-1:0]                   base_ppn,
	input  logic [$clog2(TABLE_PAGES+1)-1:0]   next_free,
	input  ptr_req_t                           req,
	output ptr_rsp_t                           rsp
);

	logic             sub;
	logic [PPN_W-1:0] b_op;
	logic [PPN_W-1:0] sum;

	assign sub  = (req.op == PTR_SUB);
	assign b_op = base_ppn ^ {PPN_W{sub}};
	assign sum  = req.operand + b_op + PPN_W'(sub);

	assign rsp.result     = sum;
	assign rsp.below_free = (sum < PPN_W'(next_free));

endmodule

### hw/rtl/sv39ptb_walker.sv
// Sequencer that clears the table store, walks levels 2 and 1, takes pages and writes entries.
// Depends on sv39ptb_pkg, sv39ptb_ptr_unit and the assertion defines header; drives the table store port.
`include "sv39_page_table_builder_unit_defines.svh"
module sv39ptb_walker import sv39ptb_pkg::*; #(
	parameter int TABLE_PAGES = TABLE_PAGES_DEF
) (
	input  logic                                                 clk,
	input  logic                                                 arst_n,
	input  logic [PPN_W-1:0]                                     base_ppn,
	input  logic                                                 in_valid,
	output logic                                                 in_stall,
	input  in_item_t                                             in_data,
	output logic                                                 out_valid,
	input  logic                                                 out_stall,
	output out_item_t                                            out_data,
	output logic [$clog2(TABLE_PAGES)+IDX_W-1:0]                 ram_addr,
	output logic                                                 ram_we,
	output logic [PTE_W-1:0]                                     ram_wdata,
	input  logic [PTE_W-1:0]                                     ram_rdata
);

	localparam int PW    = $clog2(TABLE_PAGES);
	localparam int NFW   = $clog2(TABLE_PAGES + 1);
	localparam int AW    = PW + IDX_W;
	localparam int DEPTH = TABLE_PAGES * ENTRIES_PER_TABLE;

	walk_state_t      state_q, state_d;
	in_item_t         item_q;
	logic [PW-1:0]    l1_page_q, l0_page_q;
	logic             new2_q, new1_q, err_q;
	logic [1:0]       needed_q;
	logic [NFW-1:0]   next_free_q;
	logic [AW-1:0]    clr_addr_q;
	logic             out_valid_q;
	out_item_t        out_q;

	ptr_req_t         ptr_req;
	ptr_rsp_t         ptr_rsp;
	logic [PW-1:0]    rel_page;
	logic [IDX_W-1:0] idx2, idx1, idx0;
	logic             accept, out_free, no_room, entry_valid;
	logic [PTE_W-1:0] leaf;

	sv39ptb_ptr_unit #(
		.TABLE_PAGES(TABLE_PAGES)
	) u_ptr (
		.base_ppn (base_ppn),
		.next_free(next_free_q),
		.req      (ptr_req),
		.rsp      (ptr_rsp)
	);

	assign idx2        = item_q.virt_page[3*IDX_W-1:2*IDX_W];
	assign idx1        = item_q.virt_page[2*IDX_W-1:IDX_W];
	assign idx0        = item_q.virt_page[IDX_W-1:0];
	assign rel_page    = ptr_rsp.result[PW-1:0];
	assign entry_valid = ram_rdata[0];
	assign accept      = in_valid && !in_stall;
	assign out_free    = !out_valid_q || !out_stall;
	assign no_room     = ((NFW+1)'(next_free_q) + (NFW+1)'(needed_q)) > (NFW+1)'(TABLE_PAGES);
	assign leaf        = {item_q.phys_page, 2'b00, item_q.permissions[PERM_W-1:1], 1'b1};

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_addr_q == AW'(DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_CHK2;
				end
			end
			ST_CHK2: begin
				if (!entry_valid) begin
					state_d = ST_ALLOC;
				end else if (!ptr_rsp.below_free) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_CHK1;
				end
			end
			ST_CHK1: begin
				if (entry_valid && !ptr_rsp.below_free) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_ALLOC;
				end
			end
			ST_ALLOC: begin
				if (no_room) begin
					state_d = ST_DONE;
				end else if (new2_q) begin
					state_d = ST_WR2;
				end else if (new1_q) begin
					state_d = ST_WR1;
				end else begin
					state_d = ST_WR0;
				end
			end
			ST_WR2: state_d = ST_WR1;
			ST_WR1: state_d = ST_WR0;
			ST_WR0: state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall        = (state_q != ST_IDLE);
		ram_we          = 1'b0;
		ram_addr        = {PW'(0), in_data.virt_page[3*IDX_W-1:2*IDX_W]};
		ram_wdata       = '0;
		ptr_req.op      = PTR_SUB;
		ptr_req.operand = ram_rdata[PTE_W-1:PPN_SHIFT];
		case (state_q)
			ST_CLEAR: begin
				ram_we   = 1'b1;
				ram_addr = clr_addr_q;
			end
			ST_CHK2: ram_addr = {rel_page, idx1};
			ST_WR2: begin
				ptr_req.op      = PTR_ADD;
				ptr_req.operand = PPN_W'(next_free_q);
				ram_we          = 1'b1;
				ram_addr        = {PW'(0), idx2};
				ram_wdata       = {ptr_rsp.result, (PPN_SHIFT-1)'(0), 1'b1};
			end
			ST_WR1: begin
				ptr_req.op      = PTR_ADD;
				ptr_req.operand = PPN_W'(next_free_q);
				ram_we          = 1'b1;
				ram_addr        = {l1_page_q, idx1};
				ram_wdata       = {ptr_rsp.result, (PPN_SHIFT-1)'(0), 1'b1};
			end
			ST_WR0: begin
				ram_we    = 1'b1;
				ram_addr  = {l0_page_q, idx0};
				ram_wdata = leaf;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			next_free_q <= NFW'(1);
			clr_addr_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
			if (state_q == ST_WR2 || state_q == ST_WR1) begin
				next_free_q <= next_free_q + NFW'(1);
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					item_q   <= in_data;
					new2_q   <= 1'b0;
					new1_q   <= 1'b0;
					err_q    <= 1'b0;
					needed_q <= 2'd0;
				end
			end
			ST_CHK2: begin
				if (!entry_valid) begin
					new2_q   <= 1'b1;
					new1_q   <= 1'b1;
					needed_q <= 2'd2;
				end else if (!ptr_rsp.below_free) begin
					err_q <= 1'b1;
				end else begin
					l1_page_q <= rel_page;
				end
			end
			ST_CHK1: begin
				if (!entry_valid) begin
					new1_q   <= 1'b1;
					needed_q <= 2'd1;
				end else if (!ptr_rsp.below_free) begin
					err_q <= 1'b1;
				end else begin
					l0_page_q <= rel_page;
				end
			end
			ST_ALLOC: begin
				if (no_room) begin
					err_q <= 1'b1;
				end
			end
			ST_WR2: l1_page_q <= next_free_q[PW-1:0];
			ST_WR1: l0_page_q <= next_free_q[PW-1:0];
			ST_DONE: begin
				if (out_free) begin
					out_q.leaf_entry    <= err_q ? '0 : leaf;
					out_q.tables_added  <= err_q ? 2'd0 : needed_q;
					out_q.out_of_tables <= err_q;
					out_q.region_end    <= item_q.last_page;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`SV39PTB_ASSERT_IMPL(a_free_in_range, clk, arst_n, 1'b1, next_free_q <= NFW'(TABLE_PAGES), "free page count beyond store")
	`SV39PTB_ASSERT_NEXT(a_free_only_on_take, clk, arst_n, state_q != ST_WR2 && state_q != ST_WR1, $stable(next_free_q), "free page count moved outside a table write")
	`SV39PTB_ASSERT_IMPL(a_error_word_zero, clk, arst_n, out_valid_q && out_q.out_of_tables, out_q.leaf_entry == '0 && out_q.tables_added == 2'd0, "error word carries a mapping")

endmodule

### hw/rtl/sv39_page_table_builder_unit.sv
// Top level of the Sv39 page table builder: base register, walker and table store.
// Depends on sv39ptb_pkg, sv39ptb_walker and sv39ptb_ram.
//
// Channel  Direction  Handshake            Word
// cfg      in         cfg_valid/cfg_ready  table_base_ppn, 44 bits
// in       in         in_valid/in_stall    in_item_t
// out      out        out_valid/out_stall  out_item_t
//
// After reset the walker clears every entry of the table store; no word is taken meanwhile.
// A mapping over existing tables reads the level 2 and level 1 entries, then writes the leaf.
// A mapping that takes one or two new table pages also writes the new pointers; a new level 2 entry
// skips the level 1 read.
// An item that finds no free page or a stray pointer ends without writing the store.
// The single store port and its registered read set these steps; a stalled result holds the walker.
module sv39_page_table_builder_unit import sv39ptb_pkg::*; #(
	parameter int TABLE_PAGES = TABLE_PAGES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [PPN_W-1:0] cfg_data,
	input  logic             in_valid,
	output logic             in_stall,
	input  in_item_t         in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output out_item_t        out_data
);

	localparam int AW    = $clog2(TABLE_PAGES) + IDX_W;
	localparam int DEPTH = TABLE_PAGES * ENTRIES_PER_TABLE;

	logic [PPN_W-1:0] base_ppn_q;
	logic [AW-1:0]    ram_addr;
	logic             ram_we;
	logic [PTE_W-1:0] ram_wdata, ram_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_ppn_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			base_ppn_q <= cfg_data;
		end
	end

	sv39ptb_walker #(
		.TABLE_PAGES(TABLE_PAGES)
	) u_walker (
		.clk      (clk),
		.arst_n   (arst_n),
		.base_ppn (base_ppn_q),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.ram_addr (ram_addr),
		.ram_we   (ram_we),
		.ram_wdata(ram_wdata),
		.ram_rdata(ram_rdata)
	);

	sv39ptb_ram #(
		.WIDTH(PTE_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.addr (ram_addr),
		.we   (ram_we),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

endmodule

### sim/sv39_page_table_builder_unit_test.sv
// Testbench for sv39_page_table_builder_unit: drives page mappings and base register writes,
// predicts every result word from its own copy of the table store and checks each one.
// Depends on sv39ptb_pkg and the builder RTL only.
module sv39_page_table_builder_unit_test;
	timeunit 1ns;
	timeprecision 1ps;
	import sv39ptb_pkg::*;

	localparam int NUM_TABLES = TABLE_PAGES_DEF;
	localparam int WATCHDOG_LIMIT = 100000;
	localparam int DRAIN_CYCLES = 20;
	localparam logic [PPN_W-1:0] PPN_MAX = {PPN_W{1'b1}};

	logic             clk;
	logic             arst_n = 1'b0;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [PPN_W-1:0] cfg_data = '0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	in_item_t         in_data = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	out_item_t        out_data;

	bit [PTE_W-1:0] table_mem [NUM_TABLES*ENTRIES_PER_TABLE];
	int             free_page = 1;
	bit [PPN_W-1:0] base_ppn = '0;
	out_item_t      pending_results[$];
	bit [17:0]      prefix_pool[$];
	int             sender_idle_pct = 0;
	int             recv_stall_pct = 0;
	int             err_count = 0;
	int             quiet_cycles = 0;

	sv39_page_table_builder_unit #(.TABLE_PAGES(NUM_TABLES)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit resolve_pointer(input bit [PTE_W-1:0] pte, output int page);
		bit [PPN_W-1:0] rel;
		rel = pte[PTE_W-1:PPN_SHIFT] - base_ppn;
		page = 0;
		if (rel >= PPN_W'(free_page))
			return 1'b0;
		page = int'(rel);
		return 1'b1;
	endfunction

	function automatic bit [PTE_W-1:0] pointer_entry(int page);
		bit [PPN_W-1:0] ppn;
		ppn = base_ppn + PPN_W'(page);
		return {ppn, 9'd0, 1'b1};
	endfunction

	function automatic out_item_t predict_mapping(in_item_t item);
		int i2, i1, i0, page1, page0, needed;
		bit fresh2, fresh1, ok;
		bit [PTE_W-1:0] entry, leaf;
		out_item_t res;
		i2 = int'(item.virt_page[26:18]);
		i1 = int'(item.virt_page[17:9]);
		i0 = int'(item.virt_page[8:0]);
		page1 = 0;
		page0 = 0;
		needed = 0;
		ok = 1'b1;
		fresh1 = 1'b0;
		entry = table_mem[i2];
		fresh2 = !entry[0];
		if (fresh2) begin
			needed = 2;
			fresh1 = 1'b1;
		end else if (!resolve_pointer(entry, page1)) begin
			ok = 1'b0;
		end else begin
			entry = table_mem[page1*ENTRIES_PER_TABLE + i1];
			fresh1 = !entry[0];
			if (fresh1)
				needed = 1;
			else if (!resolve_pointer(entry, page0))
				ok = 1'b0;
		end
		if (ok && free_page + needed > NUM_TABLES)
			ok = 1'b0;
		res.region_end = item.last_page;
		if (!ok) begin
			res.leaf_entry = '0;
			res.tables_added = 2'd0;
			res.out_of_tables = 1'b1;
			return res;
		end
		if (fresh2) begin
			page1 = free_page;
			free_page = free_page + 1;
			table_mem[i2] = pointer_entry(page1);
		end
		if (fresh1) begin
			page0 = free_page;
			free_page = free_page + 1;
			table_mem[page1*ENTRIES_PER_TABLE + i1] = pointer_entry(page0);
		end
		leaf = {item.phys_page, 2'b00, item.permissions} | PTE_W'(1);
		table_mem[page0*ENTRIES_PER_TABLE + i0] = leaf;
		res.leaf_entry = leaf;
		res.tables_added = 2'(needed);
		res.out_of_tables = 1'b0;
		return res;
	endfunction

	function automatic in_item_t make_item(bit [VPN_W-1:0] vpn, bit [PPN_W-1:0] ppn,
			bit [PERM_W-1:0] perm, bit last);
		in_item_t item;
		item.virt_page = vpn;
		item.phys_page = ppn;
		item.permissions = perm;
		item.last_page = last;
		return item;
	endfunction

	function automatic in_item_t random_mapping();
		int pick;
		bit [17:0] prefix;
		bit [63:0] wide;
		bit [VPN_W-1:0] vpn;
		bit [PPN_W-1:0] ppn;
		pick = $urandom_range(99);
		if (prefix_pool.size() != 0)
			prefix = prefix_pool[$urandom_range(prefix_pool.size() - 1)];
		else
			prefix = 18'($urandom);
		if (pick < 1)
			vpn = VPN_W'($urandom);
		else if (pick < 4)
			vpn = {prefix[17:9], 18'($urandom)};
		else if (pick < 6)
			vpn = $urandom_range(1) ? {VPN_W{1'b1}} : {VPN_W{1'b0}};
		else
			vpn = {prefix, 9'($urandom)};
		wide = {$urandom, $urandom};
		pick = $urandom_range(9);
		if (pick == 0)
			ppn = base_ppn + PPN_W'($urandom_range(8));
		else if (pick == 1)
			ppn = $urandom_range(1) ? PPN_MAX : '0;
		else
			ppn = wide[PPN_W-1:0];
		return make_item(vpn, ppn, PERM_W'($urandom), 1'($urandom));
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("tb: mismatch in %s: got %0h, expected %0h at %0t", what, got, want, $time);
		err_count++;
	endtask

	task automatic send_mapping(in_item_t item);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		do @(posedge clk); while (in_stall);
		pending_results.push_back(predict_mapping(item));
		prefix_pool.push_back(item.virt_page[26:9]);
	endtask

	task automatic stop_and_drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic program_base(bit [PPN_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		base_ppn = value;
	endtask

	task automatic test_directed_extremes();
		sender_idle_pct = 0;
		recv_stall_pct = 0;
		program_base('0);
		send_mapping(make_item('0, '0, 8'h00, 1'b0));
		send_mapping(make_item({VPN_W{1'b1}}, PPN_MAX, 8'hFF, 1'b1));
		send_mapping(make_item({9'd0, 9'd1, 9'd5}, 44'h123_4567_89AB, 8'h0E, 1'b0));
		send_mapping(make_item({9'd0, 9'd1, 9'd6}, 44'hEDC_BA98_7654, 8'h31, 1'b1));
		for (int b = 0; b < PERM_W; b++)
			send_mapping(make_item({18'd0, 9'(b + 10)}, PPN_W'(b) << (b * 5), 8'(1 << b), 1'(b)));
		send_mapping(make_item('0, 44'h000_0000_0001, 8'hC0, 1'b1));
		stop_and_drain();
	endtask

	task automatic test_pointer_cases();
		// A shifted base makes old pointers stray, or lands them on the wrong page.
		program_base(44'd5);
		send_mapping(make_item('0, 44'h0AA_0000_0000, 8'h07, 1'b0));
		send_mapping(make_item({9'd3, 9'd4, 9'd5}, 44'h555_5555_5555, 8'h0B, 1'b1));
		send_mapping(make_item({9'd3, 9'd4, 9'd9}, 44'h2AA_AAAA_AAAA, 8'h03, 1'b0));
		stop_and_drain();
		program_base(44'd1);
		send_mapping(make_item({9'd0, 9'd0, 9'd5}, 44'd2, 8'h0F, 1'b0));
		send_mapping(make_item({9'd5, 9'd1, 9'd7}, 44'h00F_0F0F_0F0F, 8'h05, 1'b1));
		stop_and_drain();
	endtask

	task automatic test_random_mappings(int count, int idle_pct, int stall_pct,
			bit [PPN_W-1:0] base);
		sender_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		program_base(base);
		repeat (count)
			send_mapping(random_mapping());
		stop_and_drain();
	endtask

	task automatic test_table_exhaustion();
		for (int n = 0; n < 34; n++)
			send_mapping(make_item({9'(9'h100 + n), 18'($urandom)}, 44'($urandom),
				PERM_W'($urandom), 1'($urandom)));
		for (int n = 0; n < 3; n++)
			send_mapping(make_item({9'h100, 9'(9'h1F0 + n), 9'($urandom)}, 44'($urandom),
				PERM_W'($urandom), 1'b1));
		stop_and_drain();
	endtask

	always @(posedge clk)
		out_stall <= ($urandom_range(99) < recv_stall_pct);

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected word", 64'(out_data), '0);
			end else begin
				want = pending_results.pop_front();
				if (out_data.leaf_entry !== want.leaf_entry)
					report_mismatch("leaf_entry", 64'(out_data.leaf_entry), 64'(want.leaf_entry));
				if (out_data.tables_added !== want.tables_added)
					report_mismatch("tables_added", 64'(out_data.tables_added),
						64'(want.tables_added));
				if (out_data.out_of_tables !== want.out_of_tables)
					report_mismatch("out_of_tables", 64'(out_data.out_of_tables),
						64'(want.out_of_tables));
				if (out_data.region_end !== want.region_end)
					report_mismatch("region_end", 64'(out_data.region_end), 64'(want.region_end));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_extremes();
		test_pointer_cases();
		test_random_mappings(450, 0, 0, '0);
		test_random_mappings(150, 64, 0, PPN_MAX);
		test_random_mappings(400, 64, 0, '0);
		test_random_mappings(150, 0, 64, {12'($urandom), 32'($urandom)});
		test_random_mappings(400, 0, 64, '0);
		test_random_mappings(300, 8, 8, '0);
		test_table_exhaustion();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch("results left over", 64'(pending_results.size()), '0);
		if (err_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
